/* rtl/core/hzp_pkg.sv */
package hzp_pkg;

   localparam int HZP_PHASE_WIDTH = 16;

   localparam int HZP_CSR_WIDTH  = 16;
   localparam int HZP_CSR_IDX_W  = 3;
   localparam int HZP_WIN_W      = 16;
   localparam int HZP_POLL_W     = 8;
   localparam int HZP_DEB_W      = 4;
   localparam int HZP_DUTY_W     = 7;
   localparam int HZP_LEVEL_W    = 8;
   localparam int HZP_PROD_W     = HZP_WIN_W + HZP_DUTY_W;

   localparam logic [HZP_WIN_W-1:0]  HZP_WINDOW_RST   = 16'd10000;
   localparam logic [HZP_POLL_W-1:0] HZP_POLL_RST     = 8'd20;
   localparam logic [HZP_DEB_W-1:0]  HZP_DEBOUNCE_RST = 4'd3;
   localparam logic [HZP_DUTY_W-1:0] HZP_DUTY_LOW_RST = 7'd33;
   localparam logic [HZP_DUTY_W-1:0] HZP_DUTY_MED_RST = 7'd66;
   localparam logic [HZP_DUTY_W-1:0] HZP_DUTY_HI_RST  = 7'd100;

   localparam logic [HZP_DUTY_W-1:0] HZP_PERCENT    = 7'd100;
   localparam logic [HZP_DEB_W-1:0]  HZP_STABLE_MAX = 4'd15;

   localparam logic [HZP_LEVEL_W-1:0] HZP_LEVEL_LOW    = 8'd0;
   localparam logic [HZP_LEVEL_W-1:0] HZP_LEVEL_MEDIUM = 8'd1;
   localparam logic [HZP_LEVEL_W-1:0] HZP_LEVEL_HIGH   = 8'd2;

   typedef enum logic [HZP_CSR_IDX_W-1:0] {
      CSR_WINDOW_TICKS     = 3'd0,
      CSR_POLL_TICKS       = 3'd1,
      CSR_DEBOUNCE_SAMPLES = 3'd2,
      CSR_DUTY_LOW         = 3'd3,
      CSR_DUTY_MEDIUM      = 3'd4,
      CSR_DUTY_HIGH        = 3'd5
   } hzp_csr_type;

   typedef struct packed {
      logic power_on;
      logic toggled;
   } hzp_power_type;

   typedef struct packed {
      logic relay_on;
      logic window_start;
   } hzp_win_type;

endpackage

/* rtl/core/hzp_debounce.sv */
module hzp_debounce import hzp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  button_pressed,
   input  logic                  power_write_valid,
   input  logic                  power_write_value,
   input  logic [HZP_POLL_W-1:0] poll_ticks,
   input  logic [HZP_DEB_W-1:0]  debounce_samples,
   output hzp_power_type         power
);

   logic [HZP_POLL_W-1:0] poll_count_ff, poll_count_in;
   logic [HZP_DEB_W-1:0]  stable_count_ff, stable_count_in;
   logic                  last_sample_ff, last_sample_in;
   logic                  press_held_ff, press_held_in;
   logic                  power_flag_ff, power_flag_in;
   logic [HZP_POLL_W-1:0] poll_inc;
   logic                  sample;
   logic                  toggle;

   always_comb begin
      poll_inc        = poll_count_ff + 1'b1;
      sample          = (poll_inc >= poll_ticks);
      poll_count_in   = sample ? '0 : poll_inc;
      stable_count_in = stable_count_ff;
      last_sample_in  = last_sample_ff;
      press_held_in   = press_held_ff;
      toggle          = 1'b0;
      if (sample) begin
         if (button_pressed == last_sample_ff) begin
            if (stable_count_ff != HZP_STABLE_MAX) begin
               stable_count_in = stable_count_ff + 1'b1;
            end
         end else begin
            stable_count_in = HZP_DEB_W'(1);
            last_sample_in  = button_pressed;
         end
         // zero debounce count makes every sample stable
         if (stable_count_in >= debounce_samples) begin
            toggle        = button_pressed & ~press_held_ff;
            press_held_in = button_pressed;
         end
      end
      // external write wins over a press in the same tick
      power_flag_in  = power_write_valid ? power_write_value : (power_flag_ff ^ toggle);
      power.power_on = power_flag_in;
      power.toggled  = toggle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_count_ff   <= '0;
         stable_count_ff <= '0;
         last_sample_ff  <= 1'b0;
         press_held_ff   <= 1'b0;
         power_flag_ff   <= 1'b0;
      end else if (advance) begin
         poll_count_ff   <= poll_count_in;
         stable_count_ff <= stable_count_in;
         last_sample_ff  <= last_sample_in;
         press_held_ff   <= press_held_in;
         power_flag_ff   <= power_flag_in;
      end
   end

endmodule

/* rtl/core/hzp_window.sv */
module hzp_window import hzp_pkg::*; #(
   parameter int PHASE_WIDTH = HZP_PHASE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   power_on,
   input  logic [HZP_LEVEL_W-1:0] heat_level,
   input  logic [HZP_WIN_W-1:0]   window_ticks,
   input  logic [HZP_DUTY_W-1:0]  duty_low,
   input  logic [HZP_DUTY_W-1:0]  duty_medium,
   input  logic [HZP_DUTY_W-1:0]  duty_high,
   output hzp_win_type            win
);

   localparam int CW = (PHASE_WIDTH > HZP_WIN_W) ? PHASE_WIDTH : HZP_WIN_W;
   localparam int SW = (PHASE_WIDTH + 8 > HZP_PROD_W) ? PHASE_WIDTH + 8 : HZP_PROD_W;
   localparam logic [PHASE_WIDTH-1:0] PHASE_MAX = {PHASE_WIDTH{1'b1}};

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in, phase_inc;
   // on_time is kept as window_ticks*duty, compared against 100*(phase+1)
   logic [HZP_PROD_W-1:0]  prod_ff, prod_in, prod_sel;
   logic [HZP_DUTY_W-1:0]  duty_sel, duty;
   logic [SW-1:0]          phase_scaled;
   logic                   start;

   always_comb begin
      case (heat_level)
         HZP_LEVEL_LOW:    duty_sel = duty_low;
         HZP_LEVEL_MEDIUM: duty_sel = duty_medium;
         HZP_LEVEL_HIGH:   duty_sel = duty_high;
         default:          duty_sel = duty_low;
      endcase
      if (!power_on) begin
         duty = '0;
      end else if (duty_sel > HZP_PERCENT) begin
         duty = HZP_PERCENT;
      end else begin
         duty = duty_sel;
      end

      start    = (phase_ff == '0);
      prod_in  = start ? (HZP_PROD_W'(window_ticks) * HZP_PROD_W'(duty)) : prod_ff;
      prod_sel = prod_in;

      // phase < min(floor(prod/100), PHASE_MAX)
      phase_scaled = (SW'(phase_ff) + SW'(1)) * SW'(HZP_PERCENT);
      win.relay_on     = (phase_ff != PHASE_MAX) && (phase_scaled <= SW'(prod_sel));
      win.window_start = start;

      phase_inc = phase_ff + 1'b1;
      phase_in  = (CW'(phase_inc) >= CW'(window_ticks)) ? '0 : phase_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         prod_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         prod_ff  <= prod_in;
      end
   end

endmodule

/* rtl/core/heater_zone_power_and_duty_window_core.sv */
// an accepted request passes through the input register and then the result register to its response
// one transaction per cycle, sustained while rsp_stall stays low
// the per-tick state loop (sampler, power flag, window phase) updates from its own registers on each advance
// reset clears the tick state: power off, phase zero so the first tick starts a window
// reset loads the csr registers with their defaults
module heater_zone_power_and_duty_window_core import hzp_pkg::*; #(
   parameter int PHASE_WIDTH = HZP_PHASE_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_button_pressed,
   input  logic                     req_power_write_valid,
   input  logic                     req_power_write_value,
   input  logic [HZP_LEVEL_W-1:0]   req_heat_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_relay_on,
   output logic                     rsp_relay_pin_n,
   output logic                     rsp_power_on,
   output logic                     rsp_toggled,
   output logic                     rsp_window_start,
   input  logic                     csr_wr_en,
   input  logic [HZP_CSR_IDX_W-1:0] csr_index,
   input  logic [HZP_CSR_WIDTH-1:0] csr_wdata
);

   logic [HZP_WIN_W-1:0]   window_ticks_ff;
   logic [HZP_POLL_W-1:0]  poll_ticks_ff;
   logic [HZP_DEB_W-1:0]   debounce_samples_ff;
   logic [HZP_DUTY_W-1:0]  duty_low_ff, duty_medium_ff, duty_high_ff;

   logic                   in_valid_ff;
   logic                   btn_ff, wr_valid_ff, wr_value_ff;
   logic [HZP_LEVEL_W-1:0] level_ff;

   logic                   rsp_valid_ff;
   logic                   relay_ff, power_ff, toggled_ff, start_ff;

   logic                   advance;
   logic                   load_in;
   hzp_power_type          power;
   hzp_win_type            win;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff     <= HZP_WINDOW_RST;
         poll_ticks_ff       <= HZP_POLL_RST;
         debounce_samples_ff <= HZP_DEBOUNCE_RST;
         duty_low_ff         <= HZP_DUTY_LOW_RST;
         duty_medium_ff      <= HZP_DUTY_MED_RST;
         duty_high_ff        <= HZP_DUTY_HI_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_TICKS:     window_ticks_ff     <= csr_wdata[HZP_WIN_W-1:0];
            CSR_POLL_TICKS:       poll_ticks_ff       <= csr_wdata[HZP_POLL_W-1:0];
            CSR_DEBOUNCE_SAMPLES: debounce_samples_ff <= csr_wdata[HZP_DEB_W-1:0];
            CSR_DUTY_LOW:         duty_low_ff         <= csr_wdata[HZP_DUTY_W-1:0];
            CSR_DUTY_MEDIUM:      duty_medium_ff      <= csr_wdata[HZP_DUTY_W-1:0];
            CSR_DUTY_HIGH:        duty_high_ff        <= csr_wdata[HZP_DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // the held transaction moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load_in   = !in_valid_ff || advance;
   assign req_stall = !load_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load_in) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         btn_ff      <= req_button_pressed;
         wr_valid_ff <= req_power_write_valid;
         wr_value_ff <= req_power_write_value;
         level_ff    <= req_heat_level;
      end
   end

   hzp_debounce u_debounce (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .button_pressed    (btn_ff),
      .power_write_valid (wr_valid_ff),
      .power_write_value (wr_value_ff),
      .poll_ticks        (poll_ticks_ff),
      .debounce_samples  (debounce_samples_ff),
      .power             (power)
   );

   hzp_window #(
      .PHASE_WIDTH (PHASE_WIDTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .power_on     (power.power_on),
      .heat_level   (level_ff),
      .window_ticks (window_ticks_ff),
      .duty_low     (duty_low_ff),
      .duty_medium  (duty_medium_ff),
      .duty_high    (duty_high_ff),
      .win          (win)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         relay_ff   <= win.relay_on;
         power_ff   <= power.power_on;
         toggled_ff <= power.toggled;
         start_ff   <= win.window_start;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_relay_on     = relay_ff;
   assign rsp_relay_pin_n  = ~relay_ff;
   assign rsp_power_on     = power_ff;
   assign rsp_toggled      = toggled_ff;
   assign rsp_window_start = start_ff;

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed transaction produced no response");

   a_stall_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_stall_means_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked transaction");

   a_off_window_no_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_start && !rsp_power_on |-> !rsp_relay_on)
      else $error("relay energized at window start with power off");

endmodule

/* verif/tb.sv */
module tb;
   import hzp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam logic [HZP_PHASE_WIDTH-1:0] PHASE_MAX = '1;

   typedef struct packed {
      logic relay_on;
      logic relay_pin_n;
      logic power_on;
      logic toggled;
      logic window_start;
   } tick_result_type;

   // mirrors the heater zone state and predicts one result per tick
   class heat_scoreboard;
      logic [HZP_WIN_W-1:0]       window_ticks;
      logic [HZP_POLL_W-1:0]      poll_ticks;
      logic [HZP_DEB_W-1:0]       debounce_samples;
      logic [HZP_DUTY_W-1:0]      duty_pct [3];
      logic [HZP_PHASE_WIDTH-1:0] window_phase;
      logic [HZP_PHASE_WIDTH-1:0] on_time;
      logic [HZP_POLL_W-1:0]      poll_count;
      logic [HZP_DEB_W-1:0]       stable_count;
      logic                       last_sample;
      logic                       press_held;
      logic                       power_flag;
      tick_result_type            expected_q [$];
      int                         errors;

      function new();
         window_ticks     = HZP_WINDOW_RST;
         poll_ticks       = HZP_POLL_RST;
         debounce_samples = HZP_DEBOUNCE_RST;
         duty_pct[0]      = HZP_DUTY_LOW_RST;
         duty_pct[1]      = HZP_DUTY_MED_RST;
         duty_pct[2]      = HZP_DUTY_HI_RST;
         window_phase     = '0;
         on_time          = '0;
         poll_count       = '0;
         stable_count     = '0;
         last_sample      = 1'b0;
         press_held       = 1'b0;
         power_flag       = 1'b0;
         errors           = 0;
      endfunction

      function void set_reg(hzp_csr_type idx, logic [HZP_CSR_WIDTH-1:0] value);
         case (idx)
            CSR_WINDOW_TICKS: begin
               window_ticks = value[HZP_WIN_W-1:0];
            end
            CSR_POLL_TICKS: begin
               poll_ticks = value[HZP_POLL_W-1:0];
            end
            CSR_DEBOUNCE_SAMPLES: begin
               debounce_samples = value[HZP_DEB_W-1:0];
            end
            CSR_DUTY_LOW: begin
               duty_pct[0] = value[HZP_DUTY_W-1:0];
            end
            CSR_DUTY_MEDIUM: begin
               duty_pct[1] = value[HZP_DUTY_W-1:0];
            end
            CSR_DUTY_HIGH: begin
               duty_pct[2] = value[HZP_DUTY_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_tick(logic btn, logic wr_valid, logic wr_value,
                              logic [HZP_LEVEL_W-1:0] level);
         tick_result_type         res;
         logic [HZP_DUTY_W-1:0]   duty;
         logic [HZP_PROD_W-1:0]   scaled;
         res = '0;
         // button sampler, sampled before the external write
         poll_count = poll_count + 1'b1;
         if (poll_count >= poll_ticks) begin
            poll_count = '0;
            if (btn == last_sample) begin
               if (stable_count < HZP_STABLE_MAX)
                  stable_count = stable_count + 1'b1;
            end else begin
               stable_count = HZP_DEB_W'(1);
               last_sample  = btn;
            end
            if (stable_count >= debounce_samples) begin
               if (btn && !press_held) begin
                  power_flag  = !power_flag;
                  res.toggled = 1'b1;
               end
               press_held = btn;
            end
         end
         if (wr_valid)
            power_flag = wr_value;
         // duty latched only at the window start
         if (window_phase == '0) begin
            res.window_start = 1'b1;
            if (level > HZP_LEVEL_HIGH)
               level = HZP_LEVEL_LOW;
            duty = power_flag ? duty_pct[level[1:0]] : '0;
            if (duty > HZP_PERCENT)
               duty = HZP_PERCENT;
            scaled = (HZP_PROD_W'(window_ticks) * HZP_PROD_W'(duty)) /
                     HZP_PROD_W'(HZP_PERCENT);
            if (scaled > HZP_PROD_W'(PHASE_MAX))
               on_time = PHASE_MAX;
            else
               on_time = scaled[HZP_PHASE_WIDTH-1:0];
         end
         res.relay_on    = window_phase < on_time;
         res.relay_pin_n = !res.relay_on;
         res.power_on    = power_flag;
         window_phase = window_phase + 1'b1;
         if (window_phase >= window_ticks)
            window_phase = '0;
         expected_q.push_back(res);
      endfunction

      function void compare_field(string name, logic want, logic got);
         if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
         end
      endfunction

      function void check_tick(tick_result_type got);
         tick_result_type want;
         if (expected_q.size() == 0) begin
            $error("response transaction with nothing pending");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("relay_on", want.relay_on, got.relay_on);
         compare_field("relay_pin_n", want.relay_pin_n, got.relay_pin_n);
         compare_field("power_on", want.power_on, got.power_on);
         compare_field("toggled", want.toggled, got.toggled);
         compare_field("window_start", want.window_start, got.window_start);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_button_pressed;
   logic                     req_power_write_valid;
   logic                     req_power_write_value;
   logic [HZP_LEVEL_W-1:0]   req_heat_level;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_relay_on;
   logic                     rsp_relay_pin_n;
   logic                     rsp_power_on;
   logic                     rsp_toggled;
   logic                     rsp_window_start;
   logic                     csr_wr_en;
   logic [HZP_CSR_IDX_W-1:0] csr_index;
   logic [HZP_CSR_WIDTH-1:0] csr_wdata;

   heat_scoreboard sb;
   int             quiet_cycles = 0;
   int             stall_run = 0;
   int             stall_pct = 0;
   int             idle_pct = 0;
   int             burst_left = 0;
   int             btn_run = 0;
   logic           btn_level = 1'b0;

   logic [HZP_LEVEL_W-1:0] probe_levels [6] = '{HZP_LEVEL_LOW, HZP_LEVEL_MEDIUM,
      HZP_LEVEL_HIGH, HZP_LEVEL_HIGH + 8'd1, 8'hFF, 8'h80};

   heater_zone_power_and_duty_window_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_button_pressed    (req_button_pressed),
      .req_power_write_valid (req_power_write_valid),
      .req_power_write_value (req_power_write_value),
      .req_heat_level        (req_heat_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_relay_on          (rsp_relay_on),
      .rsp_relay_pin_n       (rsp_relay_pin_n),
      .rsp_power_on          (rsp_power_on),
      .rsp_toggled           (rsp_toggled),
      .rsp_window_start      (rsp_window_start),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver holds stall or no-stall for runs of random length
   always @(posedge clock) begin
      if (stall_run == 0) begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         stall_run <= $urandom_range(1, 12);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_tick(req_button_pressed, req_power_write_valid,
                         req_power_write_value, req_heat_level);
         if (rsp_valid && !rsp_stall)
            sb.check_tick('{rsp_relay_on, rsp_relay_pin_n, rsp_power_on,
                            rsp_toggled, rsp_window_start});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_tick(input logic btn, input logic wr_valid, input logic wr_value,
                            input logic [HZP_LEVEL_W-1:0] level);
      req_valid             <= 1'b1;
      req_button_pressed    <= btn;
      req_power_write_valid <= wr_valid;
      req_power_write_value <= wr_value;
      req_heat_level        <= level;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // first edge lets the last accepted transaction reach the scoreboard
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input hzp_csr_type idx, input int unsigned value);
      logic [HZP_CSR_WIDTH-1:0] keep;
      logic [HZP_CSR_WIDTH-1:0] data;
      case (idx)
         CSR_WINDOW_TICKS: begin
            keep = '1;
         end
         CSR_POLL_TICKS: begin
            keep = 16'h00FF;
         end
         CSR_DEBOUNCE_SAMPLES: begin
            keep = 16'h000F;
         end
         default: begin
            keep = 16'h007F;
         end
      endcase
      // junk above the register width must be dropped
      data = (HZP_CSR_WIDTH'(value) & keep) | (HZP_CSR_WIDTH'($urandom) & ~keep);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic configure(input int unsigned win, input int unsigned poll,
                            input int unsigned deb, input int unsigned d_low,
                            input int unsigned d_med, input int unsigned d_high);
      drain();
      csr_write(CSR_WINDOW_TICKS, win);
      csr_write(CSR_POLL_TICKS, poll);
      csr_write(CSR_DEBOUNCE_SAMPLES, deb);
      csr_write(CSR_DUTY_LOW, d_low);
      csr_write(CSR_DUTY_MEDIUM, d_med);
      csr_write(CSR_DUTY_HIGH, d_high);
      csr_wr_en <= 1'b0;
   endtask

   task automatic sender_gap();
      if (burst_left == 0) begin
         if ($urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // button held long enough to debounce most of the time, short glitches otherwise
   task automatic random_tick();
      int                     poll_eff;
      int                     deb_eff;
      logic                   wr_valid;
      logic                   wr_value;
      logic [HZP_LEVEL_W-1:0] level;
      poll_eff = (sb.poll_ticks == 0) ? 1 : int'(sb.poll_ticks);
      deb_eff  = (sb.debounce_samples == 0) ? 1 : int'(sb.debounce_samples);
      if (btn_run == 0) begin
         btn_level = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : !btn_level;
         if ($urandom_range(0, 99) < 85)
            btn_run = $urandom_range(poll_eff * deb_eff, poll_eff * (deb_eff + 3));
         else
            btn_run = $urandom_range(1, 2 * poll_eff);
      end
      btn_run--;
      wr_valid = ($urandom_range(0, 99) < 6);
      wr_value = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 20)
         level = HZP_LEVEL_W'($urandom_range(0, 255));
      else
         level = HZP_LEVEL_W'($urandom_range(0, 2));
      sender_gap();
      send_tick(btn_level, wr_valid, wr_value, level);
   endtask

   task automatic run_phase(input int n_items, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2)
            drain();
         random_tick();
      end
   endtask

   initial begin
      sb = new();
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_button_pressed    <= 1'b0;
      req_power_write_valid <= 1'b0;
      req_power_write_value <= 1'b0;
      req_heat_level        <= '0;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_WINDOW_TICKS;
      csr_wdata             <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: first tick starts a window with power off
      send_tick(1'b0, 1'b0, 1'b0, HZP_LEVEL_HIGH);
      send_tick(1'b0, 1'b1, 1'b1, HZP_LEVEL_MEDIUM);
      send_tick(1'b1, 1'b0, 1'b0, 8'hFF);
      send_tick(1'b0, 1'b0, 1'b0, HZP_LEVEL_LOW);

      // zero poll and debounce, duty over one hundred, short window
      configure(2, 0, 0, 127, 50, 100);
      send_tick(1'b0, 1'b0, 1'b0, HZP_LEVEL_LOW);
      send_tick(1'b1, 1'b0, 1'b0, HZP_LEVEL_LOW);
      for (int i = 0; i < 6; i++) begin
         send_tick(1'b0, 1'b0, 1'b0, probe_levels[i]);
         send_tick(1'b0, 1'b0, 1'b0, probe_levels[i]);
      end
      // press and write in the same transaction, write wins
      send_tick(1'b1, 1'b1, 1'b0, HZP_LEVEL_HIGH);
      send_tick(1'b0, 1'b1, 1'b1, HZP_LEVEL_MEDIUM);
      send_tick(1'b1, 1'b1, 1'b1, HZP_LEVEL_LOW);

      configure(7, 1, 1, 0, 50, 100);
      run_phase(150, 0, 0);
      configure(0, 0, 0, 127, 100, 101);
      run_phase(80, 40, 30);
      configure(1, 1, 15, 100, 100, 100);
      run_phase(120, 20, 50);
      configure(65535, 255, 15, 100, 100, 100);
      run_phase(60, 50, 20);
      configure(100, 2, 3, 33, 66, 100);
      run_phase(150, 30, 30);
      for (int p = 0; p < 5; p++) begin
         configure(($urandom_range(0, 3) == 0) ? $urandom_range(49, 400)
                                               : $urandom_range(1, 48),
                   $urandom_range(0, 5), $urandom_range(0, 6),
                   $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 127));
         run_phase(110, $urandom_range(0, 80), $urandom_range(0, 60));
      end

      drain();
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
